>>> hw/rtl/trpq_pkg.sv
package trpq_pkg;

    // Action codes carried on the request channel.
    localparam logic [1:0] ACT_PUSH  = 2'd0;
    localparam logic [1:0] ACT_POP   = 2'd1;
    localparam logic [1:0] ACT_FORCE = 2'd2;
    localparam logic [1:0] ACT_CLEAR = 2'd3;

    // Status codes returned on the response channel.
    localparam logic [2:0] STAT_PUSHED  = 3'd0;
    localparam logic [2:0] STAT_REFUSED = 3'd1;
    localparam logic [2:0] STAT_POPPED  = 3'd2;
    localparam logic [2:0] STAT_NONE    = 3'd3;
    localparam logic [2:0] STAT_CLEARED = 3'd4;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_SORTED   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LIMIT    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OVERHEAD = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DEPTH    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD     = 3'd4;

    // Reset values of the configuration registers.
    localparam logic [31:0] RST_BYTE_LIMIT = 32'h4000_0000;
    localparam logic [7:0]  RST_OVERHEAD   = 8'd32;

    // Time scale constants.
    localparam logic [29:0] NS_PER_SEC = 30'd1000000000;
    localparam logic [19:0] NS_PER_MS  = 20'd1000000;

    localparam int DEPTH_DEFAULT = 64;
    localparam int ENTRIES_W     = 7;

    typedef struct packed {
        logic [31:0] sec;
        logic [29:0] nsec;
    } ts_t;

    typedef struct packed {
        logic [31:0] pkt_ref;
        logic [15:0] pkt_len;
        ts_t         ts;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    // Request to the span checker.
    typedef struct packed {
        logic        start;
        ts_t         head;
        ts_t         tail;
        logic [30:0] hold_ms;
    } span_req_t;

    // Answer from the span checker.
    typedef struct packed {
        logic done;
        logic released;
    } span_rsp_t;

endpackage

>>> hw/rtl/trpq_if.sv
// Request channel: one queue operation per word.
interface trpq_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [31:0] pkt_ref;
    logic [15:0] pkt_len;
    logic [31:0] ts_sec;
    logic [29:0] ts_nsec;

    modport source (output valid, action, pkt_ref, pkt_len, ts_sec, ts_nsec, input ready);
    modport sink (input valid, action, pkt_ref, pkt_len, ts_sec, ts_nsec, output ready);
endinterface

// Response channel: one result word per request.
interface trpq_rsp_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [31:0] out_ref;
    logic [15:0] out_len;
    logic [6:0]  entries_now;
    logic [31:0] bytes_now;

    modport source (output valid, status, out_ref, out_len, entries_now, bytes_now,
                    input ready);
    modport sink (input valid, status, out_ref, out_len, entries_now, bytes_now,
                  output ready);
endinterface

// Configuration write channel.
interface trpq_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

>>> hw/rtl/trpq_ram.sv
module trpq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port, one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/trpq_span.sv
module trpq_span
    import trpq_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  span_req_t req,
    output span_rsp_t rsp
);

    logic signed [32:0] dsec;
    logic signed [30:0] dnsec;
    logic signed [63:0] sec_ns_reg;
    logic signed [63:0] sec_ns_next;
    logic signed [30:0] dnsec_reg;
    logic [50:0]        hold_ns_reg;
    logic [50:0]        hold_ns_next;
    logic signed [63:0] span;
    logic               stage1_reg;
    logic               stage2_reg;
    logic               released_reg;

    // Stage one: scale the seconds difference and the hold time to nanoseconds.
    assign dsec  = $signed({1'b0, req.tail.sec}) - $signed({1'b0, req.head.sec});
    assign dnsec = $signed({1'b0, req.tail.nsec}) - $signed({1'b0, req.head.nsec});
    assign sec_ns_next  = 64'(dsec) * $signed({34'd0, NS_PER_SEC});
    assign hold_ns_next = 51'(req.hold_ms) * 51'(NS_PER_MS);

    always_ff @(posedge clk)
    begin
        sec_ns_reg  <= sec_ns_next;
        dnsec_reg   <= dnsec;
        hold_ns_reg <= hold_ns_next;
    end

    // Stage two: full span against the hold time.
    assign span = sec_ns_reg + 64'(dnsec_reg);

    always_ff @(posedge clk)
    begin
        released_reg <= span > $signed({13'd0, hold_ns_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage1_reg <= 1'b0;
            stage2_reg <= 1'b0;
        end
        else
        begin
            stage1_reg <= req.start;
            stage2_reg <= stage1_reg;
        end
    end

    assign rsp.done     = stage2_reg;
    assign rsp.released = released_reg;

endmodule

>>> hw/rtl/timestamp_reorder_packet_queue_top.sv
// Timestamp-ordered packet descriptor queue.
// Requests arrive on req (push, normal pop, forced pop, clear); each gives
// exactly one response word on rsp with a status, the popped reference and
// length, and the entry count and byte total after the operation.
// Configuration is written on cfg (index 0 sorted mode, 1 byte limit,
// 2 entry overhead, 3 sort depth, 4 hold time in ms); cfg is always ready.
// Entries live in one RAM used as a ring; a pop moves the head pointer.
// One request is worked on at a time. A sorted push scans the RAM from
// the head, then moves every later entry up one place; each entry read
// goes through the single read port of the ring RAM.
// The response sits in an output register; the next request is taken while
// it waits, and the queue stalls only when a new result is ready and the
// previous one has not been taken. Reset empties the queue and loads the
// register defaults; stored entries need no clearing.
module timestamp_reorder_packet_queue_top
    import trpq_pkg::*;
#(
    parameter int DEPTH = DEPTH_DEFAULT
) (
    input logic       clk,
    input logic       rst_n,
    trpq_cfg_if.sink  cfg,
    trpq_req_if.sink  req,
    trpq_rsp_if.source rsp
);

    localparam int AW   = $clog2(DEPTH);
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int SW   = CW + 1;
    localparam int CMPW = (CW > 7) ? CW : 7;

    typedef enum logic [12:0] {
        S_IDLE = 13'b0000000000001,
        S_HRD  = 13'b0000000000010,
        S_HEAD = 13'b0000000000100,
        S_TAIL = 13'b0000000001000,
        S_SPAN = 13'b0000000010000,
        S_POP  = 13'b0000000100000,
        S_SCAN = 13'b0000001000000,
        S_SCMP = 13'b0000010000000,
        S_SHRD = 13'b0000100000000,
        S_SHWR = 13'b0001000000000,
        S_WRITE = 13'b0010000000000,
        S_WAIT = 13'b0100000000000,
        S_DONE = 13'b1000000000000
    } state_t;

    state_t state_reg, state_next;

    logic        sorted_reg;
    logic [31:0] limit_reg;
    logic [7:0]  overhead_reg;
    logic [6:0]  sdepth_reg;
    logic [30:0] hold_reg;

    logic [CW-1:0] count_reg, count_next;
    logic [AW-1:0] head_reg, head_next;
    logic [31:0]   bytes_reg, bytes_next;

    logic [1:0]    act_reg, act_next;
    entry_t        new_reg, new_next;
    logic [32:0]   need_reg, need_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [CW-1:0] pos_reg, pos_next;
    entry_t        head_ent_reg, head_ent_next;

    logic [2:0]  res_status_reg, res_status_next;
    logic [31:0] res_ref_reg, res_ref_next;
    logic [15:0] res_len_reg, res_len_next;

    logic        rsp_valid_reg, rsp_valid_next;
    logic [2:0]  rsp_status_reg, rsp_status_next;
    logic [31:0] rsp_ref_reg, rsp_ref_next;
    logic [15:0] rsp_len_reg, rsp_len_next;
    logic [6:0]  rsp_entries_reg, rsp_entries_next;
    logic [31:0] rsp_bytes_reg, rsp_bytes_next;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    entry_t        ram_wdata;
    logic [AW-1:0] ram_raddr;
    entry_t        ram_rdata;

    span_req_t span_req;
    span_rsp_t span_rsp;

    logic        accept;
    logic [32:0] need_calc;
    logic        refused;
    logic        depth_hold;
    logic        later;
    logic [16:0] charge;

    // Ring position of the entry at a given distance from the head.
    function automatic logic [AW-1:0] phys(input logic [AW-1:0] base,
                                           input logic [CW-1:0] off);
        logic [SW-1:0] s;
        begin
            s = SW'(base) + SW'(off);
            if (s >= SW'(DEPTH))
            begin
                s = s - SW'(DEPTH);
            end
            return s[AW-1:0];
        end
    endfunction

    trpq_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    trpq_span u_span (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (span_req),
        .rsp   (span_rsp)
    );

    assign cfg.ready = 1'b1;
    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sorted_reg   <= 1'b0;
            limit_reg    <= RST_BYTE_LIMIT;
            overhead_reg <= RST_OVERHEAD;
            sdepth_reg   <= '0;
            hold_reg     <= '0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_SORTED:   sorted_reg   <= cfg.data[0];
                REG_LIMIT:    limit_reg    <= cfg.data;
                REG_OVERHEAD: overhead_reg <= cfg.data[7:0];
                REG_DEPTH:    sdepth_reg   <= cfg.data[6:0];
                REG_HOLD:     hold_reg     <= cfg.data[30:0];
                default:      ;
            endcase
        end
    end

    // Checks made when a request is taken.
    assign need_calc  = 33'(bytes_reg) + 33'(req.pkt_len) + 33'(overhead_reg);
    assign refused    = (count_reg >= CW'(DEPTH)) || (need_calc > {1'b0, limit_reg});
    assign depth_hold = (sdepth_reg != '0) && (CMPW'(count_reg) <= CMPW'(sdepth_reg));

    // Stored entry is strictly later than the one being pushed.
    assign later = (ram_rdata.ts.sec > new_reg.ts.sec) ||
                   ((ram_rdata.ts.sec == new_reg.ts.sec) &&
                    (ram_rdata.ts.nsec > new_reg.ts.nsec));

    assign charge = 17'(head_ent_reg.pkt_len) + 17'(overhead_reg);

    assign span_req.start   = (state_reg == S_TAIL);
    assign span_req.head    = head_ent_reg.ts;
    assign span_req.tail    = ram_rdata.ts;
    assign span_req.hold_ms = hold_reg;

    // Sequencer.
    always_comb
    begin
        state_next       = state_reg;
        count_next       = count_reg;
        head_next        = head_reg;
        bytes_next       = bytes_reg;
        act_next         = act_reg;
        new_next         = new_reg;
        need_next        = need_reg;
        idx_next         = idx_reg;
        pos_next         = pos_reg;
        head_ent_next    = head_ent_reg;
        res_status_next  = res_status_reg;
        res_ref_next     = res_ref_reg;
        res_len_next     = res_len_reg;
        rsp_valid_next   = rsp_valid_reg;
        rsp_status_next  = rsp_status_reg;
        rsp_ref_next     = rsp_ref_reg;
        rsp_len_next     = rsp_len_reg;
        rsp_entries_next = rsp_entries_reg;
        rsp_bytes_next   = rsp_bytes_reg;
        ram_we           = 1'b0;
        ram_waddr        = phys(head_reg, pos_reg);
        ram_wdata        = new_reg;
        ram_raddr        = phys(head_reg, '0);

        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    act_next        = req.action;
                    new_next        = '{pkt_ref: req.pkt_ref, pkt_len: req.pkt_len,
                                        ts: '{sec: req.ts_sec, nsec: req.ts_nsec}};
                    need_next       = need_calc;
                    res_ref_next    = '0;
                    res_len_next    = '0;
                    res_status_next = STAT_NONE;
                    idx_next        = '0;
                    pos_next        = count_reg;
                    case (req.action)
                        ACT_PUSH:
                        begin
                            if (refused)
                            begin
                                res_status_next = STAT_REFUSED;
                                state_next      = S_DONE;
                            end
                            else if (sorted_reg && (count_reg != '0))
                            begin
                                state_next = S_SCAN;
                            end
                            else
                            begin
                                state_next = S_WRITE;
                            end
                        end
                        ACT_CLEAR:
                        begin
                            count_next      = '0;
                            head_next       = '0;
                            bytes_next      = '0;
                            res_status_next = STAT_CLEARED;
                            state_next      = S_DONE;
                        end
                        default:
                        begin
                            if ((count_reg == '0) ||
                                (sorted_reg && (req.action == ACT_POP) && depth_hold))
                            begin
                                state_next = S_DONE;
                            end
                            else
                            begin
                                state_next = S_HRD;
                            end
                        end
                    endcase
                end
            end

            // Pop: read the head, then optionally the tail for the span check.
            S_HRD:
            begin
                ram_raddr  = phys(head_reg, '0);
                state_next = S_HEAD;
            end
            S_HEAD:
            begin
                head_ent_next = ram_rdata;
                if (sorted_reg && (act_reg == ACT_POP) && (hold_reg != '0))
                begin
                    if (count_reg == CW'(1))
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        ram_raddr  = phys(head_reg, count_reg - CW'(1));
                        state_next = S_TAIL;
                    end
                end
                else
                begin
                    state_next = S_POP;
                end
            end
            S_TAIL:
            begin
                state_next = S_SPAN;
            end
            S_SPAN:
            begin
                if (span_rsp.done)
                begin
                    state_next = span_rsp.released ? S_POP : S_DONE;
                end
            end
            S_POP:
            begin
                res_status_next = STAT_POPPED;
                res_ref_next    = head_ent_reg.pkt_ref;
                res_len_next    = head_ent_reg.pkt_len;
                head_next       = phys(head_reg, CW'(1));
                count_next      = count_reg - CW'(1);
                bytes_next      = (32'(charge) >= bytes_reg) ? '0 : bytes_reg - 32'(charge);
                state_next      = S_DONE;
            end

            // Sorted push: find the first later entry from the head.
            S_SCAN:
            begin
                ram_raddr  = phys(head_reg, idx_reg);
                state_next = S_SCMP;
            end
            S_SCMP:
            begin
                if (later)
                begin
                    pos_next   = idx_reg;
                    idx_next   = count_reg;
                    state_next = S_SHRD;
                end
                else if (idx_reg + CW'(1) == count_reg)
                begin
                    pos_next   = count_reg;
                    state_next = S_WRITE;
                end
                else
                begin
                    idx_next   = idx_reg + CW'(1);
                    state_next = S_SCAN;
                end
            end

            // Move entries from the tail down to the insert point up by one.
            S_SHRD:
            begin
                ram_raddr  = phys(head_reg, idx_reg - CW'(1));
                state_next = S_SHWR;
            end
            S_SHWR:
            begin
                ram_we    = 1'b1;
                ram_waddr = phys(head_reg, idx_reg);
                ram_wdata = ram_rdata;
                idx_next  = idx_reg - CW'(1);
                if (idx_reg - CW'(1) == pos_reg)
                begin
                    state_next = S_WRITE;
                end
                else
                begin
                    state_next = S_SHRD;
                end
            end
            S_WRITE:
            begin
                ram_we          = 1'b1;
                ram_waddr       = phys(head_reg, pos_reg);
                ram_wdata       = new_reg;
                count_next      = count_reg + CW'(1);
                bytes_next      = need_reg[31:0];
                res_status_next = STAT_PUSHED;
                state_next      = S_DONE;
            end

            // Hand the result to the output register once it is free.
            S_DONE:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next   = 1'b1;
                    rsp_status_next  = res_status_reg;
                    rsp_ref_next     = res_ref_reg;
                    rsp_len_next     = res_len_reg;
                    rsp_entries_next = ENTRIES_W'(count_reg);
                    rsp_bytes_next   = bytes_reg;
                    state_next       = S_IDLE;
                end
            end
            S_WAIT:
            begin
                state_next = S_DONE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            head_reg      <= '0;
            bytes_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            head_reg      <= head_next;
            bytes_reg     <= bytes_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        act_reg         <= act_next;
        new_reg         <= new_next;
        need_reg        <= need_next;
        idx_reg         <= idx_next;
        pos_reg         <= pos_next;
        head_ent_reg    <= head_ent_next;
        res_status_reg  <= res_status_next;
        res_ref_reg     <= res_ref_next;
        res_len_reg     <= res_len_next;
        rsp_status_reg  <= rsp_status_next;
        rsp_ref_reg     <= rsp_ref_next;
        rsp_len_reg     <= rsp_len_next;
        rsp_entries_reg <= rsp_entries_next;
        rsp_bytes_reg   <= rsp_bytes_next;
    end

    assign rsp.valid       = rsp_valid_reg;
    assign rsp.status      = rsp_status_reg;
    assign rsp.out_ref     = rsp_ref_reg;
    assign rsp.out_len     = rsp_len_reg;
    assign rsp.entries_now = rsp_entries_reg;
    assign rsp.bytes_now   = rsp_bytes_reg;

endmodule
